>>> hdl/pfm_pkg.sv
// Shared types and constants of the pulse flow meter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pfm_pkg;

    // Counting and calibration sizes.
    localparam int DECILES          = 10;
    localparam int PULSE_COUNT_BITS = 16;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int T_W     = 16;
    localparam int FREQ_W  = 24;
    localparam int DEC_W   = 4;
    localparam int FLOW_W  = 26;
    localparam int IVOL_W  = 32;
    localparam int TVOL_W  = 48;
    localparam int TIME_W  = 40;
    localparam int CAP_W   = 10;
    localparam int K_W     = 16;
    localparam int MF_W    = 16;

    // Datapath widths derived from the fields.
    localparam int SCALE_W    = 18;
    localparam int F_NUM_W    = PULSE_COUNT_BITS + SCALE_W;
    localparam int PROD_W     = FREQ_W + MF_W;
    localparam int CAPK_W     = CAP_W + K_W;
    localparam int ACC_W      = CAPK_W + 4;
    localparam int F10_W      = FREQ_W + 4;
    localparam int RT_W       = FLOW_W + T_W;
    localparam int RT25_W     = RT_W + 5;
    localparam int V_SHIFT    = 9;
    localparam int V1_W       = RT25_W - V_SHIFT;
    localparam int DIVISOR_W  = K_W + 4;
    localparam int DIV_W      = (F_NUM_W > PROD_W) ? F_NUM_W : PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [SCALE_W-1:0] FREQ_SCALE = SCALE_W'(256000);
    localparam logic [DEC_W-1:0]   DEC_MAX    = DEC_W'(DECILES - 1);

    // Division by three as a reciprocal multiplication: for x below 2^34,
    // x/3 is (x * 0x2AAAAAAAB) >> 35. The constant is split into a high and
    // a low part so that each product stays narrow.
    localparam int RECIP_X_W       = 34;
    localparam int RECIP_LO_W      = 18;
    localparam int RECIP_HI_W      = 16;
    localparam int RECIP_SHIFT     = 35;
    localparam int RECIP_LO_PROD_W = RECIP_X_W + RECIP_LO_W;
    localparam int RECIP_HI_PROD_W = RECIP_X_W + RECIP_HI_W;
    localparam int RECIP_SUM_W     = RECIP_X_W + RECIP_LO_W + RECIP_HI_W;
    localparam logic [RECIP_LO_W-1:0] RECIP_LO = 18'h2AAAB;
    localparam logic [RECIP_HI_W-1:0] RECIP_HI = 16'hAAAA;
    // At or above this the interval volume saturates.
    localparam logic [V1_W-1:0] V1_SAT = V1_W'(64'h3_0000_0000);

    // Item codes.
    localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M_0_3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M_4_7    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M_8_9    = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 10'd60;
    localparam logic [K_W-1:0]   K_RESET   = 16'd1280;
    localparam logic [63:0]      M4_RESET  = 64'h4000_4000_4000_4000;
    localparam logic [31:0]      M2_RESET  = 32'h4000_4000;

    // Tick queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [T_W-1:0]  elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_q8;
        logic [DEC_W-1:0]  decile;
        logic [FLOW_W-1:0] flow_rate;
        logic [IVOL_W-1:0] interval_volume_ul;
        logic [TVOL_W-1:0] total_volume_ul;
        logic [TIME_W-1:0] total_ms;
    } result_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [K_W-1:0]   k_factor;
        logic [63:0]      m_0_3;
        logic [63:0]      m_4_7;
        logic [31:0]      m_8_9;
    } cfg_t;

    typedef struct packed {
        logic [PULSE_COUNT_BITS-1:0] pulses;
        logic [T_W-1:0]              elapsed_ms;
    } tick_t;

    typedef struct packed {
        logic  valid;
        tick_t tick;
    } queue_port_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hdl/pfm_front.sv
// Front end of the pulse flow meter: takes items, keeps the pulse count
// and hands each tick to the tick queue. Depends on pfm_pkg.
`timescale 1ns / 1ps

module pfm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  pfm_pkg::sample_t sample,
    input  logic             queue_full,
    output pfm_pkg::queue_port_t queue_wr
);
    import pfm_pkg::*;

    logic [PULSE_COUNT_BITS-1:0] pulse_count_reg;
    logic [PULSE_COUNT_BITS-1:0] pulse_count_next;
    logic                        accept;

    // Only a tick needs room in the queue; pulses and clears go on.
    assign sample_stall = queue_full && (sample.op == OP_TICK);
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        pulse_count_next         = pulse_count_reg;
        queue_wr.valid           = 1'b0;
        queue_wr.tick.pulses     = pulse_count_reg;
        queue_wr.tick.elapsed_ms = sample.elapsed_ms;
        if (accept)
        begin
            unique case (sample.op)
                OP_PULSE:
                begin
                    if (pulse_count_reg != '1)
                    begin
                        pulse_count_next = pulse_count_reg + 1'b1;
                    end
                end
                OP_TICK:
                begin
                    queue_wr.valid   = 1'b1;
                    pulse_count_next = '0;
                end
                OP_CLEAR:
                begin
                    pulse_count_next = '0;
                end
                default:
                begin
                    pulse_count_next = pulse_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
        end
        else
        begin
            pulse_count_reg <= pulse_count_next;
        end
    end

endmodule

>>> hdl/pfm_queue.sv
// Short tick queue between the front end and the back end.
// Depends on pfm_pkg.
`timescale 1ns / 1ps

module pfm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfm_pkg::queue_port_t wr,
    output logic                 full,
    output pfm_pkg::queue_port_t rd,
    input  logic                 pop
);
    import pfm_pkg::*;

    tick_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.tick  = entry_reg[rd_ptr_reg];
    assign do_push  = wr.valid && !full;
    assign do_pop   = pop && rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr.tick;
        end
    end

endmodule

>>> hdl/pfm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// The dividend comes left-aligned; iters sets the number of quotient bits.
// Depends on pfm_pkg.
`timescale 1ns / 1ps

module pfm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfm_pkg::div_req_t req,
    output pfm_pkg::div_rsp_t rsp
);
    import pfm_pkg::*;

    logic [DIV_W-1:0]     q_reg;
    logic [DIV_W-1:0]     q_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W-1:0] divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg, q_reg[DIV_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    always_comb
    begin
        q_next       = q_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(rem_shift - {1'b0, divisor_reg})
                            : rem_shift[DIVISOR_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            q_next       = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            cnt_next     = req.iters;
            busy_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

endmodule

>>> hdl/pfm_back.sv
// Back end of the pulse flow meter: works one tick at a time through
// frequency, decile, flow and volume, keeps the totals and holds the result.
// Depends on pfm_pkg and pfm_div.
`timescale 1ns / 1ps

module pfm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfm_pkg::cfg_t        cfg,
    input  pfm_pkg::queue_port_t queue_rd,
    output logic                 queue_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output pfm_pkg::result_t     result
);
    import pfm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_LOAD_F   = 13'b0000000000010,
        S_WAIT_F   = 13'b0000000000100,
        S_DEC_INIT = 13'b0000000001000,
        S_DEC_STEP = 13'b0000000010000,
        S_MULT_M   = 13'b0000000100000,
        S_LOAD_R   = 13'b0000001000000,
        S_WAIT_R   = 13'b0000010000000,
        S_MUL_T    = 13'b0000100000000,
        S_SCALE_V  = 13'b0001000000000,
        S_RECIP_LO = 13'b0010000000000,
        S_RECIP_HI = 13'b0100000000000,
        S_FINISH   = 13'b1000000000000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [PULSE_COUNT_BITS-1:0] p_reg;
    logic [PULSE_COUNT_BITS-1:0] p_next;
    logic [T_W-1:0]              t_reg;
    logic [T_W-1:0]              t_next;
    logic [FREQ_W-1:0]           f_reg;
    logic [FREQ_W-1:0]           f_next;
    logic [DEC_W-1:0]            d_reg;
    logic [DEC_W-1:0]            d_next;
    logic [MF_W-1:0]             m_reg;
    logic [MF_W-1:0]             m_next;
    logic [CAPK_W-1:0]           capk_reg;
    logic [CAPK_W-1:0]           capk_next;
    logic [ACC_W-1:0]            acc_reg;
    logic [ACC_W-1:0]            acc_next;
    logic [F10_W-1:0]            f10_reg;
    logic [F10_W-1:0]            f10_next;
    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W-1:0]           prod_next;
    logic [FLOW_W-1:0]           r_reg;
    logic [FLOW_W-1:0]           r_next;
    logic [RT_W-1:0]             rt_reg;
    logic [RT_W-1:0]             rt_next;
    logic [V1_W-1:0]             v1_reg;
    logic [V1_W-1:0]             v1_next;
    logic [RECIP_LO_PROD_W-1:0]  vlo_reg;
    logic [RECIP_LO_PROD_W-1:0]  vlo_next;
    logic [IVOL_W-1:0]           v_reg;
    logic [IVOL_W-1:0]           v_next;
    logic [TVOL_W-1:0]           total_vol_reg;
    logic [TVOL_W-1:0]           total_vol_next;
    logic [TIME_W-1:0]           total_time_reg;
    logic [TIME_W-1:0]           total_time_next;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    result_t                     result_reg;
    result_t                     result_next;

    logic [F_NUM_W-1:0]          f_num;
    logic [CAPK_W-1:0]           capk;
    logic [RT25_W-1:0]           rt25;
    logic [RECIP_X_W-1:0]        recip_x;
    logic [RECIP_HI_PROD_W-1:0]  recip_hi_prod;
    logic [RECIP_SUM_W-1:0]      recip_sum;
    logic                        v1_big;
    logic [TVOL_W:0]             vol_sum;
    logic [TIME_W:0]             time_sum;
    logic [TVOL_W-1:0]           vol_sat;
    logic [TIME_W-1:0]           time_sat;
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;

    // Selects the m-factor of a decile from the three packed registers.
    function automatic logic [MF_W-1:0] pick_m(cfg_t c, logic [DEC_W-1:0] d);
        logic [MF_W-1:0] m;
        begin
            m = '0;
            priority if (d < DEC_W'(4))
            begin
                m = c.m_0_3[MF_W * d[1:0] +: MF_W];
            end
            else if (d < DEC_W'(8))
            begin
                m = c.m_4_7[MF_W * d[1:0] +: MF_W];
            end
            else
            begin
                m = c.m_8_9[MF_W * d[0] +: MF_W];
            end
            return m;
        end
    endfunction

    pfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign f_num    = F_NUM_W'(p_reg) * F_NUM_W'(FREQ_SCALE);
    assign capk     = CAPK_W'(cfg.capacity) * CAPK_W'(cfg.k_factor);
    assign rt25     = (RT25_W'(rt_reg) << 4) + (RT25_W'(rt_reg) << 3) + RT25_W'(rt_reg);
    assign vol_sum  = {1'b0, total_vol_reg} + (TVOL_W + 1)'(v_reg);
    assign time_sum = {1'b0, total_time_reg} + (TIME_W + 1)'(t_reg);
    assign vol_sat  = vol_sum[TVOL_W] ? '1 : vol_sum[TVOL_W-1:0];
    assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

    // Below the saturation point the scaled volume fits the reciprocal's range.
    assign v1_big        = (v1_reg >= V1_SAT);
    assign recip_x       = v1_reg[RECIP_X_W-1:0];
    assign recip_hi_prod = RECIP_HI_PROD_W'(recip_x) * RECIP_HI_PROD_W'(RECIP_HI);
    assign recip_sum     = (RECIP_SUM_W'(recip_hi_prod) << RECIP_LO_W) + RECIP_SUM_W'(vlo_reg);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Divider requests: each dividend is left-aligned in the divider word.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(f_num) << (DIV_W - F_NUM_W);
        div_req.divisor  = DIVISOR_W'(t_reg);
        div_req.iters    = DIV_CNT_W'(F_NUM_W);
        unique case (state_reg)
            S_LOAD_F:
            begin
                div_req.start = 1'b1;
            end
            S_LOAD_R:
            begin
                div_req.start    = (cfg.k_factor != '0);
                div_req.dividend = DIV_W'(prod_reg) << (DIV_W - PROD_W);
                div_req.divisor  = {cfg.k_factor, 4'b0000};
                div_req.iters    = DIV_CNT_W'(PROD_W);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        p_next            = p_reg;
        t_next            = t_reg;
        f_next            = f_reg;
        d_next            = d_reg;
        m_next            = m_reg;
        capk_next         = capk_reg;
        acc_next          = acc_reg;
        f10_next          = f10_reg;
        prod_next         = prod_reg;
        r_next            = r_reg;
        rt_next           = rt_reg;
        v1_next           = v1_reg;
        vlo_next          = vlo_reg;
        v_next            = v_reg;
        total_vol_next    = total_vol_reg;
        total_time_next   = total_time_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        queue_pop         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (queue_rd.valid)
                begin
                    queue_pop = 1'b1;
                    p_next    = queue_rd.tick.pulses;
                    t_next    = queue_rd.tick.elapsed_ms;
                    f_next    = '0;
                    d_next    = '0;
                    r_next    = '0;
                    v_next    = '0;
                    // With no elapsed time everything but the totals is zero.
                    state_next = (queue_rd.tick.elapsed_ms == '0) ? S_FINISH : S_LOAD_F;
                end
            end
            S_LOAD_F:
            begin
                state_next = S_WAIT_F;
            end
            S_WAIT_F:
            begin
                if (div_rsp.done)
                begin
                    f_next = (|div_rsp.quotient[DIV_W-1:FREQ_W]) ? '1
                                                                 : div_rsp.quotient[FREQ_W-1:0];
                    state_next = S_DEC_INIT;
                end
            end
            S_DEC_INIT:
            begin
                capk_next  = capk;
                acc_next   = ACC_W'(capk);
                f10_next   = (F10_W'(f_reg) << 3) + (F10_W'(f_reg) << 1);
                d_next     = '0;
                state_next = S_DEC_STEP;
            end
            S_DEC_STEP:
            begin
                // The decile is the count of multiples of capacity*k that
                // stay at or below ten times the frequency, up to nine.
                if (f_reg != '0 && d_reg != DEC_MAX && acc_reg <= ACC_W'(f10_reg))
                begin
                    d_next   = d_reg + 1'b1;
                    acc_next = acc_reg + ACC_W'(capk_reg);
                end
                else
                begin
                    state_next = S_MULT_M;
                end
            end
            S_MULT_M:
            begin
                m_next     = pick_m(cfg, d_reg);
                prod_next  = PROD_W'(f_reg) * PROD_W'(pick_m(cfg, d_reg));
                state_next = S_LOAD_R;
            end
            S_LOAD_R:
            begin
                if (cfg.k_factor == '0)
                begin
                    r_next     = (f_reg != '0 && m_reg != '0) ? '1 : '0;
                    state_next = S_MUL_T;
                end
                else
                begin
                    state_next = S_WAIT_R;
                end
            end
            S_WAIT_R:
            begin
                if (div_rsp.done)
                begin
                    r_next = (|div_rsp.quotient[DIV_W-1:FLOW_W]) ? '1
                                                                 : div_rsp.quotient[FLOW_W-1:0];
                    state_next = S_MUL_T;
                end
            end
            S_MUL_T:
            begin
                rt_next    = RT_W'(r_reg) * RT_W'(t_reg);
                state_next = S_SCALE_V;
            end
            S_SCALE_V:
            begin
                // Volume is R*T*25/1536: scale by 25, drop 512, divide by 3.
                v1_next    = rt25[RT25_W-1:V_SHIFT];
                state_next = S_RECIP_LO;
            end
            S_RECIP_LO:
            begin
                vlo_next   = RECIP_LO_PROD_W'(recip_x) * RECIP_LO_PROD_W'(RECIP_LO);
                state_next = S_RECIP_HI;
            end
            S_RECIP_HI:
            begin
                v_next     = v1_big ? '1 : recip_sum[RECIP_SHIFT +: IVOL_W];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    total_vol_next                 = vol_sat;
                    total_time_next                = time_sat;
                    result_next.frequency_q8       = f_reg;
                    result_next.decile             = d_reg;
                    result_next.flow_rate          = r_reg;
                    result_next.interval_volume_ul = v_reg;
                    result_next.total_volume_ul    = vol_sat;
                    result_next.total_ms           = time_sat;
                    result_valid_next              = 1'b1;
                    state_next                     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            total_vol_reg    <= '0;
            total_time_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_vol_reg    <= total_vol_next;
            total_time_reg   <= total_time_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        t_reg      <= t_next;
        f_reg      <= f_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        capk_reg   <= capk_next;
        acc_reg    <= acc_next;
        f10_reg    <= f10_next;
        prod_reg   <= prod_next;
        r_reg      <= r_next;
        rt_reg     <= rt_next;
        v1_reg     <= v1_next;
        vlo_reg    <= vlo_next;
        v_reg      <= v_next;
        result_reg <= result_next;
    end

endmodule

>>> hdl/pulse_flow_meter.sv
// Pulse flow meter with k-factor and per-decile m-factor calibration.
// Pulse, tick and clear items enter at the front; each tick is computed in
// the back and gives one result. Pulse and clear items are never stalled,
// and the front keeps taking them while the back works. A tick is taken as
// long as the two-entry tick queue has room; the back then works it through
// its states, with two divisions on one shared radix-2 divider that yields
// one quotient bit per cycle: PULSE_COUNT_BITS + 18 bits for frequency and
// 40 for flow. Division of the volume by three is a reciprocal multiplication,
// a low partial product and then a high one. A zero k-factor skips the flow
// division. A tick with zero elapsed time skips the computation and goes
// straight to the result. The result register lets the back start the next
// tick while a result waits to be taken.
// Depends on pfm_pkg, pfm_front, pfm_queue, pfm_div and pfm_back.
`timescale 1ns / 1ps

module pulse_flow_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  pfm_pkg::sample_t                   sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output pfm_pkg::result_t                   result,
    input  logic                               wr_en,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pfm_pkg::CFG_DATA_W-1:0]     wr_data
);
    import pfm_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    queue_port_t queue_wr;
    queue_port_t queue_rd;
    logic        queue_full;
    logic        queue_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CAPACITY: cfg_next.capacity = wr_data[CAP_W-1:0];
                REG_K_FACTOR: cfg_next.k_factor = wr_data[K_W-1:0];
                REG_M_0_3:    cfg_next.m_0_3    = wr_data;
                REG_M_4_7:    cfg_next.m_4_7    = wr_data;
                REG_M_8_9:    cfg_next.m_8_9    = wr_data[31:0];
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity <= CAP_RESET;
            cfg_reg.k_factor <= K_RESET;
            cfg_reg.m_0_3    <= M4_RESET;
            cfg_reg.m_4_7    <= M4_RESET;
            cfg_reg.m_8_9    <= M2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pfm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .queue_full   (queue_full),
        .queue_wr     (queue_wr)
    );

    pfm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (queue_wr),
        .full  (queue_full),
        .rd    (queue_rd),
        .pop   (queue_pop)
    );

    pfm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_rd     (queue_rd),
        .queue_pop    (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
